// ----- rtl/nvcb_pkg.sv -----
// Shared types and constants of the NVMe I/O command builder.
`default_nettype none

package nvcb_pkg;

  // Field widths fixed by the command format.
  localparam int unsigned TAIL_W     = 16;
  localparam int unsigned SLOT_OUT_W = 6;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned PSH_W      = 5;
  localparam int unsigned SSH_W      = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // NVMe I/O opcodes.
  localparam logic [1:0] OPC_WRITE = 2'h1;
  localparam logic [1:0] OPC_READ  = 2'h2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SHIFT = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [PSH_W-1:0] PAGE_SHIFT_RST   = 5'd12;
  localparam logic [SSH_W-1:0] SECTOR_SHIFT_RST = 4'd9;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture an accepted request into the working registers
    logic issue;  // build one command into the output register and advance
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_ok;    // the request at the input yields at least one command
    logic last_cmd;  // the command being built finishes the request
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/nvcb_ctrl.sv -----
// Controller state machine of the NVMe I/O command builder.
`default_nettype none

module nvcb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire nvcb_pkg::dp_stat_t stat,
  output nvcb_pkg::dp_cmd_t       cmd
);

  nvcb_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    in_ready  = (state_r == nvcb_pkg::ST_IDLE);
    cmd.load  = in_valid && in_ready && stat.req_ok;
    cmd.issue = (state_r == nvcb_pkg::ST_RUN) && (!out_valid_r || out_ready);
    out_valid = out_valid_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nvcb_pkg::ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = nvcb_pkg::ST_RUN;
        end
      end
      nvcb_pkg::ST_RUN: begin
        if (cmd.issue && stat.last_cmd) begin
          state_nxt = nvcb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nvcb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.issue) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nvcb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/nvcb_dp.sv -----
// Datapath of the NVMe I/O command builder: working registers, PRP math, output register.
`default_nettype none

module nvcb_dp #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned MAX_BLOCKS  = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [nvcb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [nvcb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                                in_is_write,
  input  wire logic [31:0]                         in_namespace_id,
  input  wire logic [63:0]                         in_buffer_addr,
  input  wire logic [63:0]                         in_start_lba,
  input  wire logic [nvcb_pkg::COUNT_W-1:0]        in_block_count,
  input  wire nvcb_pkg::dp_cmd_t                   cmd,
  output nvcb_pkg::dp_stat_t                       stat,
  output logic [1:0]                               out_opcode,
  output logic [nvcb_pkg::TAIL_W-1:0]              out_command_id,
  output logic [nvcb_pkg::SLOT_OUT_W-1:0]          out_queue_slot,
  output logic [31:0]                              out_cmd_namespace,
  output logic [63:0]                              out_prp_first,
  output logic [63:0]                              out_prp_second,
  output logic [63:0]                              out_cmd_lba,
  output logic [5:0]                               out_blocks_minus_one,
  output logic                                     out_more_follows,
  output logic                                     out_last
);

  localparam int unsigned SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(QUEUE_DEPTH - 1);
  localparam int unsigned CW = nvcb_pkg::COUNT_W;

  // Configuration.
  logic [nvcb_pkg::PSH_W-1:0] psh_r;
  logic [nvcb_pkg::SSH_W-1:0] ssh_r;

  // Tail counter and its value modulo the queue depth, kept in step.
  logic [nvcb_pkg::TAIL_W-1:0] tail_r, tail_nxt;
  logic [SLOT_W-1:0]           slot_r, slot_nxt;

  // Working registers of the request being split.
  logic          wr_r;
  logic [31:0]   ns_r;
  logic [63:0]   p_r, lba_r;
  logic [CW-1:0] rem_r;

  // Per-command arithmetic.
  logic [31:0]   ps;
  logic [31:0]   off;
  logic [32:0]   room;
  logic [32:0]   span;
  logic [32:0]   m;
  logic [CW-1:0] n;
  logic [21:0]   len;
  logic          spill;

  always_comb begin
    ps    = 32'(1) << psh_r;
    off   = p_r[31:0] & (ps - 32'd1);
    room  = {1'b0, ps} - {1'b0, off};
    span  = {ps, 1'b0} - {1'b0, off};
    m     = span >> ssh_r;
    if (m == 33'd0) begin
      n = CW'(1);
    end else if (m >= {{(33-CW){1'b0}}, rem_r}) begin
      n = rem_r;
    end else begin
      n = m[CW-1:0];
    end
    len   = 22'(n) << ssh_r;
    spill = {11'd0, len} > room;

    stat.req_ok   = (in_block_count != '0) && (in_block_count <= CW'(MAX_BLOCKS));
    stat.last_cmd = (rem_r == n);
  end

  always_comb begin
    tail_nxt = tail_r + 16'd1;
    if (tail_r == {nvcb_pkg::TAIL_W{1'b1}} || slot_r == SLOT_MAX) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = slot_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psh_r  <= nvcb_pkg::PAGE_SHIFT_RST;
      ssh_r  <= nvcb_pkg::SECTOR_SHIFT_RST;
      tail_r <= '0;
      slot_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          nvcb_pkg::CFG_PAGE_SHIFT:   psh_r <= cfg_wdata;
          nvcb_pkg::CFG_SECTOR_SHIFT: ssh_r <= cfg_wdata[nvcb_pkg::SSH_W-1:0];
          default: ;
        endcase
      end
      if (cmd.issue) begin
        tail_r <= tail_nxt;
        slot_r <= slot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wr_r  <= in_is_write;
      ns_r  <= in_namespace_id;
      p_r   <= in_buffer_addr;
      lba_r <= in_start_lba;
      rem_r <= in_block_count;
    end else if (cmd.issue) begin
      p_r   <= p_r + 64'(len);
      lba_r <= lba_r + 64'(n);
      rem_r <= rem_r - n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      out_opcode           <= wr_r ? nvcb_pkg::OPC_WRITE : nvcb_pkg::OPC_READ;
      out_command_id       <= tail_r;
      out_queue_slot       <= nvcb_pkg::SLOT_OUT_W'(slot_r);
      out_cmd_namespace    <= ns_r;
      out_prp_first        <= p_r;
      out_prp_second       <= spill ? (p_r + 64'(room)) : 64'd0;
      out_cmd_lba          <= lba_r;
      out_blocks_minus_one <= 6'(n - CW'(1));
      out_more_follows     <= (rem_r != n);
      out_last             <= (rem_r == n);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/nvme_io_command_builder.sv -----
// Top level of the NVMe I/O command builder: controller, datapath and checks.
`default_nettype none

// This block splits one block read or write request into NVMe read or write
// submission entries, each one result beat. A request is accepted when the
// block is idle; it then issues one command per cycle while the result side
// takes beats, keeping the input closed until its last command (of up to 64)
// is built, as its single set of working registers (address, block address,
// remaining count) is updated once per command. The next request can be taken
// in the cycle after that, while that command still waits in the output
// register. A command covers at most the rest of the current page and one
// whole page, or one block if that is wider: prp_first is the current address
// and prp_second the next page boundary, or zero when the data fits in the
// current page. Requests of zero blocks or of more than MAX_BLOCKS blocks are
// consumed and give no beats. Command ids come from a 16-bit tail counter that
// rises by one per command; the queue slot is that counter modulo QUEUE_DEPTH.
// The user must write the page and sector shift registers through the
// configuration port only while idle; the block does not enforce it. Used as written.

module nvme_io_command_builder #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned MAX_BLOCKS  = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [nvcb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [nvcb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_is_write,
  input  wire logic [31:0]                         in_namespace_id,
  input  wire logic [63:0]                         in_buffer_addr,
  input  wire logic [63:0]                         in_start_lba,
  input  wire logic [nvcb_pkg::COUNT_W-1:0]        in_block_count,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [1:0]                               out_opcode,
  output logic [nvcb_pkg::TAIL_W-1:0]              out_command_id,
  output logic [nvcb_pkg::SLOT_OUT_W-1:0]          out_queue_slot,
  output logic [31:0]                              out_cmd_namespace,
  output logic [63:0]                              out_prp_first,
  output logic [63:0]                              out_prp_second,
  output logic [63:0]                              out_cmd_lba,
  output logic [5:0]                               out_blocks_minus_one,
  output logic                                     out_more_follows,
  output logic                                     out_last
);

  nvcb_pkg::dp_cmd_t  dp_cmd;
  nvcb_pkg::dp_stat_t dp_stat;

  // The controller owns the handshake and the output valid flag.
  nvcb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // The datapath holds configuration, the tail counter, the working
  // registers of the request and the output payload register.
  nvcb_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_is_write          (in_is_write),
    .in_namespace_id      (in_namespace_id),
    .in_buffer_addr       (in_buffer_addr),
    .in_start_lba         (in_start_lba),
    .in_block_count       (in_block_count),
    .cmd                  (dp_cmd),
    .stat                 (dp_stat),
    .out_opcode           (out_opcode),
    .out_command_id       (out_command_id),
    .out_queue_slot       (out_queue_slot),
    .out_cmd_namespace    (out_cmd_namespace),
    .out_prp_first        (out_prp_first),
    .out_prp_second       (out_prp_second),
    .out_cmd_lba          (out_cmd_lba),
    .out_blocks_minus_one (out_blocks_minus_one),
    .out_more_follows     (out_more_follows),
    .out_last             (out_last)
  );

  // The slot counter must track the tail counter modulo the queue depth.
  a_slot_matches_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_queue_slot == nvcb_pkg::SLOT_OUT_W'(out_command_id % QUEUE_DEPTH))
    else $error("queue slot does not match command id");

  // Exactly one of the more-follows hint and the last flag is set on a beat.
  a_last_xor_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last != out_more_follows))
    else $error("last and more_follows disagree");

  // A request that yields commands closes the input after it is taken.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_block_count != '0 &&
     in_block_count <= nvcb_pkg::COUNT_W'(MAX_BLOCKS)) |=> !in_ready)
    else $error("input not closed after a non-empty request");

endmodule

`default_nettype wire

// ----- bench/nvcb_checker.sv -----
// Checker of the NVMe I/O command builder: predicts the command beats and compares them.
`timescale 1ns / 1ps

module nvcb_checker #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned MAX_BLOCKS  = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [nvcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nvcb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            in_is_write,
  input  logic [31:0]                     in_namespace_id,
  input  logic [63:0]                     in_buffer_addr,
  input  logic [63:0]                     in_start_lba,
  input  logic [nvcb_pkg::COUNT_W-1:0]    in_block_count,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [1:0]                      out_opcode,
  input  logic [nvcb_pkg::TAIL_W-1:0]     out_command_id,
  input  logic [nvcb_pkg::SLOT_OUT_W-1:0] out_queue_slot,
  input  logic [31:0]                     out_cmd_namespace,
  input  logic [63:0]                     out_prp_first,
  input  logic [63:0]                     out_prp_second,
  input  logic [63:0]                     out_cmd_lba,
  input  logic [5:0]                      out_blocks_minus_one,
  input  logic                            out_more_follows,
  input  logic                            out_last,
  output int unsigned                     fail_count,
  output int unsigned                     pending_cmds
);

  typedef struct packed {
    logic [1:0]                      opcode;
    logic [nvcb_pkg::TAIL_W-1:0]     command_id;
    logic [nvcb_pkg::SLOT_OUT_W-1:0] queue_slot;
    logic [31:0]                     cmd_namespace;
    logic [63:0]                     prp_first;
    logic [63:0]                     prp_second;
    logic [63:0]                     cmd_lba;
    logic [5:0]                      blocks_minus_one;
    logic                            more_follows;
    logic                            last;
  } nvme_cmd_t;

  nvme_cmd_t                      expected_cmds[$];
  nvme_cmd_t                      seen_cmd;
  nvme_cmd_t                      want_cmd;
  logic [nvcb_pkg::PSH_W-1:0]     page_shift;
  logic [nvcb_pkg::SSH_W-1:0]     sector_shift;
  logic [nvcb_pkg::TAIL_W-1:0]    cmd_tail;

  initial begin
    fail_count   = 0;
    pending_cmds = 0;
  end

  function automatic string cmd_text(nvme_cmd_t c);
    return $sformatf("op=%0d id=%h slot=%0d ns=%h prp1=%h prp2=%h lba=%h n-1=%0d more=%b last=%b",
                     c.opcode, c.command_id, c.queue_slot, c.cmd_namespace, c.prp_first,
                     c.prp_second, c.cmd_lba, c.blocks_minus_one, c.more_follows, c.last);
  endfunction

  // Splits one request into commands, each limited to the room left in the
  // current page plus one whole page, and queues them in issue order.
  function automatic void split_request(logic wr, logic [31:0] ns, logic [63:0] addr,
                                        logic [63:0] lba,
                                        logic [nvcb_pkg::COUNT_W-1:0] count);
    logic [63:0] page_size;
    logic [63:0] offset;
    logic [63:0] room;
    logic [63:0] fit;
    logic [63:0] nblk;
    logic [63:0] len;
    logic [63:0] remaining;
    nvme_cmd_t   cmd;
    page_size = 64'd1 << page_shift;
    remaining = 64'(count);
    if (remaining > MAX_BLOCKS) return;
    while (remaining != 0) begin
      offset = addr & (page_size - 64'd1);
      room   = page_size - offset;
      fit    = ((page_size << 1) - offset) >> sector_shift;
      // A block wider than two pages still moves one block per command.
      if (fit == 0) fit = 64'd1;
      nblk = (remaining < fit) ? remaining : fit;
      len  = nblk << sector_shift;
      cmd.opcode           = wr ? nvcb_pkg::OPC_WRITE : nvcb_pkg::OPC_READ;
      cmd.command_id       = cmd_tail;
      cmd.queue_slot       = nvcb_pkg::SLOT_OUT_W'(cmd_tail % QUEUE_DEPTH);
      cmd.cmd_namespace    = ns;
      cmd.prp_first        = addr;
      cmd.prp_second       = (len > room) ? addr + room : 64'd0;
      cmd.cmd_lba          = lba;
      cmd.blocks_minus_one = 6'(nblk - 64'd1);
      cmd.more_follows     = remaining > nblk;
      cmd.last             = remaining == nblk;
      expected_cmds.push_back(cmd);
      cmd_tail  = cmd_tail + 1'b1;
      addr      = addr + len;
      lba       = lba + nblk;
      remaining = remaining - nblk;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      page_shift   = nvcb_pkg::PAGE_SHIFT_RST;
      sector_shift = nvcb_pkg::SECTOR_SHIFT_RST;
      cmd_tail     = '0;
      expected_cmds.delete();
    end else begin
      // The output is registered, so a beat leaving now belongs to an
      // earlier request; compare before predicting this edge's request.
      if (out_valid && out_ready) begin
        seen_cmd.opcode           = out_opcode;
        seen_cmd.command_id       = out_command_id;
        seen_cmd.queue_slot       = out_queue_slot;
        seen_cmd.cmd_namespace    = out_cmd_namespace;
        seen_cmd.prp_first        = out_prp_first;
        seen_cmd.prp_second       = out_prp_second;
        seen_cmd.cmd_lba          = out_cmd_lba;
        seen_cmd.blocks_minus_one = out_blocks_minus_one;
        seen_cmd.more_follows     = out_more_follows;
        seen_cmd.last             = out_last;
        if (expected_cmds.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected command beat: %s", $realtime, cmd_text(seen_cmd));
        end else begin
          want_cmd = expected_cmds.pop_front();
          if (seen_cmd !== want_cmd) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("[%0t] command beat mismatch", $realtime);
              $display("  expected %s", cmd_text(want_cmd));
              $display("  actual   %s", cmd_text(seen_cmd));
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          nvcb_pkg::CFG_PAGE_SHIFT:   page_shift   = cfg_wdata[nvcb_pkg::PSH_W-1:0];
          nvcb_pkg::CFG_SECTOR_SHIFT: sector_shift = cfg_wdata[nvcb_pkg::SSH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        split_request(in_is_write, in_namespace_id, in_buffer_addr, in_start_lba,
                      in_block_count);
    end
    pending_cmds = expected_cmds.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// Top of the NVMe I/O command builder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned QUEUE_DEPTH    = 64;
  localparam int unsigned MAX_BLOCKS     = 64;
  localparam int unsigned PHASES         = 10;
  localparam int unsigned PHASE_ITEMS    = 36;
  // Cycles the block may still need after its last expected beat.
  localparam int unsigned SETTLE_CYCLES  = 8;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  // Register indexes that the block has no register for.
  localparam logic [nvcb_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [nvcb_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [nvcb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [nvcb_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            in_valid;
  logic                            in_ready;
  logic                            in_is_write;
  logic [31:0]                     in_namespace_id;
  logic [63:0]                     in_buffer_addr;
  logic [63:0]                     in_start_lba;
  logic [nvcb_pkg::COUNT_W-1:0]    in_block_count;
  logic                            out_valid;
  logic                            out_ready;
  logic [1:0]                      out_opcode;
  logic [nvcb_pkg::TAIL_W-1:0]     out_command_id;
  logic [nvcb_pkg::SLOT_OUT_W-1:0] out_queue_slot;
  logic [31:0]                     out_cmd_namespace;
  logic [63:0]                     out_prp_first;
  logic [63:0]                     out_prp_second;
  logic [63:0]                     out_cmd_lba;
  logic [5:0]                      out_blocks_minus_one;
  logic                            out_more_follows;
  logic                            out_last;
  int unsigned                     fail_count;
  int unsigned                     pending_cmds;

  int unsigned           idle_cycles = 0;
  int unsigned           rx_cycle = 0;
  int unsigned           rx_mode = 0;
  int unsigned           rx_hold = 0;
  logic                  rx_stalled = 1'b0;

  always #2 clk = ~clk;

  nvme_io_command_builder #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_is_write         (in_is_write),
    .in_namespace_id     (in_namespace_id),
    .in_buffer_addr      (in_buffer_addr),
    .in_start_lba        (in_start_lba),
    .in_block_count      (in_block_count),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_opcode          (out_opcode),
    .out_command_id      (out_command_id),
    .out_queue_slot      (out_queue_slot),
    .out_cmd_namespace   (out_cmd_namespace),
    .out_prp_first       (out_prp_first),
    .out_prp_second      (out_prp_second),
    .out_cmd_lba         (out_cmd_lba),
    .out_blocks_minus_one(out_blocks_minus_one),
    .out_more_follows    (out_more_follows),
    .out_last            (out_last)
  );

  nvcb_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_is_write         (in_is_write),
    .in_namespace_id     (in_namespace_id),
    .in_buffer_addr      (in_buffer_addr),
    .in_start_lba        (in_start_lba),
    .in_block_count      (in_block_count),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_opcode          (out_opcode),
    .out_command_id      (out_command_id),
    .out_queue_slot      (out_queue_slot),
    .out_cmd_namespace   (out_cmd_namespace),
    .out_prp_first       (out_prp_first),
    .out_prp_second      (out_prp_second),
    .out_cmd_lba         (out_cmd_lba),
    .out_blocks_minus_one(out_blocks_minus_one),
    .out_more_follows    (out_more_follows),
    .out_last            (out_last),
    .fail_count          (fail_count),
    .pending_cmds        (pending_cmds)
  );

  // Puts one request on the input channel at a falling edge and holds it
  // until the block takes the beat. The task returns right after the rising
  // edge of acceptance, so the caller decides at the next falling edge
  // whether valid stays high for another request or drops for a gap.
  task automatic send_request(input logic wr, input logic [31:0] ns, input logic [63:0] addr,
                              input logic [63:0] lba,
                              input logic [nvcb_pkg::COUNT_W-1:0] count);
    @(negedge clk);
    in_valid        <= 1'b1;
    in_is_write     <= wr;
    in_namespace_id <= ns;
    in_buffer_addr  <= addr;
    in_start_lba    <= lba;
    in_block_count  <= count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // One register write: the enable is high for exactly one rising edge.
  task automatic write_reg(input logic [nvcb_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= nvcb_pkg::CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Closes the input and lets the block drain. Requests that yield no
  // commands give no beat to wait for, so a settling wait of SETTLE_CYCLES
  // follows the last expected beat before the block is treated as idle.
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_cmds != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The result side stalls on a pattern of its own, which is picked again and
  // again at random between always ready, sparse random stalls, and
  // alternating runs of ready and stalled cycles of random length.
  always @(negedge clk) begin
    if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 2);
    rx_cycle++;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_hold == 0) begin
          rx_hold    = $urandom_range(1, 12);
          rx_stalled = ~rx_stalled;
        end
        rx_hold--;
        out_ready <= ~rx_stalled;
      end
    endcase
  end

  // Watchdog: any accepted beat on either channel shows progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no beat accepted for %0d cycles", $realtime, idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned      phase;
    int unsigned      item;
    int unsigned      burst_left;
    int unsigned      gap;
    int unsigned      pick;
    int unsigned      page_sel;
    int unsigned      sector_sel;
    logic [31:0]      hi;
    logic [31:0]      lo;
    logic [63:0]      addr;
    logic [63:0]      lba;
    logic [nvcb_pkg::COUNT_W-1:0] count;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = nvcb_pkg::CFG_PAGE_SHIFT;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_is_write     = 1'b0;
    in_namespace_id = '0;
    in_buffer_addr  = '0;
    in_start_lba    = '0;
    in_block_count  = '0;
    out_ready       = 1'b0;
    burst_left      = 0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests under the reset page and sector sizes (4 KiB pages,
    // 512-byte blocks), so the reset values of both registers are checked.
    // Smallest read at address zero.
    send_request(1'b0, 32'h0, 64'h0, 64'h0, 7'd1);
    // Largest write with every field at its top: address and block wrap.
    send_request(1'b1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                 7'd64);
    // Zero count and oversized requests are consumed without commands.
    send_request(1'b0, 32'h1234_5678, 64'h1000, 64'h10, 7'd0);
    send_request(1'b1, 32'h1, 64'h2000, 64'h20, 7'd65);
    send_request(1'b0, 32'h2, 64'h3000, 64'h30, 7'd127);
    // Exactly one page needs no second pointer; one more block does.
    send_request(1'b0, 32'hA5A5_5A5A, 64'h1000, 64'h100, 7'd8);
    send_request(1'b1, 32'h5A5A_A5A5, 64'h1000, 64'h100, 7'd9);
    // One byte before a page boundary, not block aligned.
    send_request(1'b0, 32'h7, 64'hFFF, 64'h5, 7'd1);
    // Unaligned start trims the first command below two full pages.
    send_request(1'b1, 32'h8, 64'h200, 64'h40, 7'd16);
    // Address crossing the top of memory with the block address close behind.
    send_request(1'b0, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_E000, 64'hFFFF_FFFF_FFFF_FFFE,
                 7'd40);
    send_request(1'b1, 32'h0F0F_F0F0, 64'h1234_5678_9ABC_DE00, 64'h8000_0000_0000_0000,
                 7'd64);

    for (phase = 0; phase < PHASES; phase++) begin
      // Registers change only with the block idle and nothing expected.
      drain_block();
      case (phase)
        0: begin page_sel = 16; sector_sel = 12; end
        1: begin page_sel = 12; sector_sel = 12; end
        2: begin page_sel = 16; sector_sel = 9;  end
        // Shifts beyond their stated ranges are used as written.
        3: begin page_sel = 31; sector_sel = 15; end
        // One-byte pages with 32 KiB blocks: each block exceeds two pages.
        4: begin page_sel = 0;  sector_sel = 15; end
        5: begin page_sel = 0;  sector_sel = 0;  end
        6: begin page_sel = 14; sector_sel = 11; end
        7: begin page_sel = 12; sector_sel = 9;  end
        8: begin
          page_sel   = $urandom_range(12, 16);
          sector_sel = $urandom_range(9, 12);
        end
        default: begin
          page_sel   = $urandom_range(0, 31);
          sector_sel = $urandom_range(0, 15);
        end
      endcase
      write_reg(nvcb_pkg::CFG_PAGE_SHIFT, page_sel);
      write_reg(nvcb_pkg::CFG_SECTOR_SHIFT, sector_sel);
      // Writes to indexes without a register must leave both registers alone.
      write_reg(CFG_SPARE_LO, $urandom_range(0, 31));
      write_reg(CFG_SPARE_HI, $urandom_range(0, 31));

      for (item = 0; item < PHASE_ITEMS; item++) begin
        // The sender works in bursts; a quarter of the bursts follow the
        // previous one with no gap at all.
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          if (gap != 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
          end
        end
        burst_left--;

        // Buffer address: mostly arbitrary, with aligned and near-top cases
        // so that page crossings and address wrap are both frequent.
        hi   = $urandom;
        lo   = $urandom;
        addr = {hi, lo};
        pick = $urandom_range(0, 9);
        case (pick)
          4, 5: addr = addr & ~64'hFFF;
          6, 7: addr = addr & ~64'h1FF;
          8:    addr = 64'hFFFF_FFFF_FFFF_0000 | 64'($urandom_range(0, 16'hFFFF));
          9:    addr = 64'($urandom_range(0, 16'hFFFF));
          default: ;
        endcase

        hi  = $urandom;
        lo  = $urandom;
        lba = {hi, lo};
        if ($urandom_range(0, 5) == 0)
          lba = 64'hFFFF_FFFF_FFFF_FFC0 | 64'($urandom_range(0, 63));

        // Mostly well-formed counts; some zero and some oversized requests.
        pick = $urandom_range(0, 19);
        case (pick)
          0:          count = '0;
          1:          count = nvcb_pkg::COUNT_W'($urandom_range(MAX_BLOCKS + 1, 127));
          2, 3, 4, 5: count = nvcb_pkg::COUNT_W'($urandom_range(33, MAX_BLOCKS));
          default:    count = nvcb_pkg::COUNT_W'($urandom_range(1, 32));
        endcase

        send_request(1'($urandom_range(0, 1)), $urandom, addr, lba, count);
      end
    end

    // Every request is in; wait for the last command beats and a short tail
    // in which any stray beat would still be caught.
    drain_block();
    repeat (16) @(negedge clk);

    if (fail_count == 0 && pending_cmds == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/nvcb_pkg.sv
rtl/nvcb_ctrl.sv
rtl/nvcb_dp.sv
rtl/nvme_io_command_builder.sv
bench/nvcb_checker.sv
bench/tb_top.sv
